### sv/rcf_pkg.sv
// Package for the redundant command filter: opcodes, command kinds and the
// result group that travels from the parser to the output serializer.
// No dependencies.
`default_nettype none

package rcf_pkg;

  localparam logic [7:0] OP_NOTE_LO = 8'h80;
  localparam logic [7:0] OP_NOTE_HI = 8'hDF;
  localparam logic [7:0] OP_DETUNE  = 8'hF3;
  localparam logic [7:0] OP_VOLUME  = 8'hFB;
  localparam logic [7:0] OP_QUANT   = 8'hF8;
  localparam logic [7:0] OP_PAN     = 8'hFC;
  localparam logic [7:0] OP_TEMPO   = 8'hFF;
  localparam logic [7:0] OP_LFO_DLY = 8'hE9;
  localparam logic [7:0] OP_F2      = 8'hF2;
  localparam logic [7:0] OP_F4      = 8'hF4;
  localparam logic [7:0] OP_F5      = 8'hF5;
  localparam logic [7:0] OP_F6      = 8'hF6;
  localparam logic [7:0] OP_FE      = 8'hFE;
  localparam logic [7:0] OP_E7      = 8'hE7;
  localparam logic [7:0] OP_FD      = 8'hFD;
  localparam logic [7:0] OP_F0      = 8'hF0;
  localparam logic [7:0] OP_EF      = 8'hEF;
  localparam logic [7:0] OP_ED      = 8'hED;
  localparam logic [7:0] OP_F1      = 8'hF1;
  localparam logic [7:0] OP_EA      = 8'hEA;
  localparam logic [7:0] OP_EB      = 8'hEB;
  localparam logic [7:0] OP_EC      = 8'hEC;
  localparam logic [7:0] LEN_SHORT0 = 8'h80;
  localparam logic [7:0] LEN_SHORT1 = 8'h81;

  localparam int NUM_BYTE_KINDS = 5;
  localparam int MASK_W         = 6;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DETUNE  = 3'd1,
    KIND_VOLUME  = 3'd2,
    KIND_QUANT   = 3'd3,
    KIND_PAN     = 3'd4,
    KIND_TEMPO   = 3'd5,
    KIND_LFO_DLY = 3'd6
  } rcf_kind_t;

  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_F1   = 2'd1,
    LEN_EXT  = 2'd2
  } rcf_len_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } rcf_group_t;

  typedef struct packed {
    logic       push;
    rcf_group_t grp;
  } rcf_push_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    rcf_group_t head;
  } rcf_qstat_t;

  function automatic rcf_kind_t dedup_kind(input logic [7:0] op,
                                           input logic [MASK_W-1:0] mask);
    rcf_kind_t k;
    k = KIND_NONE;
    unique case (op)
      OP_DETUNE:  k = mask[0] ? KIND_DETUNE  : KIND_NONE;
      OP_VOLUME:  k = mask[1] ? KIND_VOLUME  : KIND_NONE;
      OP_QUANT:   k = mask[2] ? KIND_QUANT   : KIND_NONE;
      OP_PAN:     k = mask[3] ? KIND_PAN     : KIND_NONE;
      OP_TEMPO:   k = mask[4] ? KIND_TEMPO   : KIND_NONE;
      OP_LFO_DLY: k = mask[5] ? KIND_LFO_DLY : KIND_NONE;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kind_opcode(input rcf_kind_t k);
    logic [7:0] op;
    op = OP_VOLUME;
    unique case (k)
      KIND_DETUNE:  op = OP_DETUNE;
      KIND_VOLUME:  op = OP_VOLUME;
      KIND_QUANT:   op = OP_QUANT;
      KIND_PAN:     op = OP_PAN;
      KIND_TEMPO:   op = OP_TEMPO;
      KIND_LFO_DLY: op = OP_LFO_DLY;
      default:      op = OP_VOLUME;
    endcase
    return op;
  endfunction

  function automatic logic [2:0] kind_slot(input rcf_kind_t k);
    logic [2:0] s;
    s = 3'd0;
    unique case (k)
      KIND_VOLUME:  s = 3'd0;
      KIND_QUANT:   s = 3'd1;
      KIND_PAN:     s = 3'd2;
      KIND_TEMPO:   s = 3'd3;
      KIND_LFO_DLY: s = 3'd4;
      default:      s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/rcf_if.sv
// Channel interfaces of the redundant command filter: input bytes, filtered
// output bytes and the mask write channel. Depends on nothing.
`default_nettype none

interface rcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface rcf_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] dedup_mask;
  modport source (output valid, output dedup_mask, input ready);
  modport sink   (input valid, input dedup_mask, output ready);
endinterface

`default_nettype wire

### sv/rcf_front.sv
// Parser of the redundant command filter: frames commands, holds dedup-able
// ones and turns each input byte into a group of zero to three result bytes.
// Depends on rcf_pkg and rcf_if.
`default_nettype none

module rcf_front
  import rcf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rcf_in_if.sink     in_chan,
  rcf_cfg_if.sink    cfg_chan,
  input  rcf_qstat_t qstat,
  output rcf_push_t  push
);

  logic [MASK_W-1:0] mask_r;
  logic [2:0]        args_r, args_nxt;
  rcf_kind_t         kind_r, kind_nxt, dk;
  logic [7:0]        high_r, high_nxt;
  rcf_len_t          lp_r, lp_nxt;
  logic [15:0]       det_r, det_nxt;
  logic              det_vld_r, det_vld_nxt;
  logic [7:0]        lv_r [NUM_BYTE_KINDS];
  logic [7:0]        lv_nxt;
  logic [NUM_BYTE_KINDS-1:0] lv_vld_r, lv_vld_nxt;
  logic              lv_we;
  logic [2:0]        slot;
  logic              fire;
  logic [7:0]        b;
  logic              eos;
  rcf_group_t        grp;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !qstat.full;
  assign fire = in_chan.valid && in_chan.ready;
  assign b    = in_chan.data_byte;
  assign eos  = in_chan.end_of_stream;
  assign slot = kind_slot(kind_r);

  always_comb begin
    args_nxt    = args_r;
    kind_nxt    = kind_r;
    high_nxt    = high_r;
    lp_nxt      = lp_r;
    det_nxt     = det_r;
    det_vld_nxt = det_vld_r;
    lv_vld_nxt  = lv_vld_r;
    lv_nxt      = b;
    lv_we       = 1'b0;
    grp.cnt     = 2'd0;
    grp.bytes   = '{default: 8'h00};
    dk          = dedup_kind(b, mask_r);
    if (kind_r == KIND_DETUNE) begin
      if (args_r >= 3'd2) begin
        high_nxt = b;
        args_nxt = 3'd1;
        if (eos) begin
          grp.cnt      = 2'd2;
          grp.bytes[0] = OP_DETUNE;
          grp.bytes[1] = b;
        end
      end else begin
        if (!(det_vld_r && det_r == {high_r, b})) begin
          det_nxt      = {high_r, b};
          det_vld_nxt  = 1'b1;
          grp.cnt      = 2'd3;
          grp.bytes[0] = OP_DETUNE;
          grp.bytes[1] = high_r;
          grp.bytes[2] = b;
        end
        args_nxt = 3'd0;
        kind_nxt = KIND_NONE;
      end
    end else if (kind_r != KIND_NONE) begin
      if (!(lv_vld_r[slot] && lv_r[slot] == b)) begin
        lv_we            = 1'b1;
        lv_vld_nxt[slot] = 1'b1;
        grp.cnt          = 2'd2;
        grp.bytes[0]     = kind_opcode(kind_r);
        grp.bytes[1]     = b;
      end
      kind_nxt = KIND_NONE;
      args_nxt = 3'd0;
    end else if (lp_r != LEN_NONE) begin
      if (lp_r == LEN_F1) begin
        args_nxt = (b == 8'h00) ? 3'd0 : 3'd1;
      end else begin
        args_nxt = (b == LEN_SHORT0 || b == LEN_SHORT1) ? 3'd0 : 3'd4;
      end
      lp_nxt       = LEN_NONE;
      grp.cnt      = 2'd1;
      grp.bytes[0] = b;
    end else if (args_r != 3'd0) begin
      args_nxt     = args_r - 3'd1;
      grp.cnt      = 2'd1;
      grp.bytes[0] = b;
    end else if (eos) begin
      grp.cnt      = 2'd1;
      grp.bytes[0] = b;
    end else if (dk != KIND_NONE) begin
      kind_nxt = dk;
      args_nxt = (dk == KIND_DETUNE) ? 3'd2 : 3'd1;
    end else begin
      grp.cnt      = 2'd1;
      grp.bytes[0] = b;
      unique case (b) inside
        [OP_NOTE_LO:OP_NOTE_HI]:                        args_nxt = 3'd1;
        OP_DETUNE, OP_F2, OP_FE, OP_F6, OP_F5, OP_F4, OP_E7: args_nxt = 3'd2;
        OP_TEMPO, OP_FD, OP_PAN, OP_VOLUME, OP_QUANT, OP_F0, OP_EF, OP_ED,
        OP_LFO_DLY:                                     args_nxt = 3'd1;
        OP_F1:                                          lp_nxt   = LEN_F1;
        OP_EA, OP_EB, OP_EC:                            lp_nxt   = LEN_EXT;
        default:                                        args_nxt = 3'd0;
      endcase
    end
    if (eos) begin
      args_nxt    = 3'd0;
      kind_nxt    = KIND_NONE;
      high_nxt    = 8'h00;
      lp_nxt      = LEN_NONE;
      det_vld_nxt = 1'b0;
      lv_vld_nxt  = '0;
    end
  end

  assign push.push = fire && (grp.cnt != 2'd0);
  assign push.grp  = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      args_r    <= '0;
      kind_r    <= KIND_NONE;
      high_r    <= '0;
      lp_r      <= LEN_NONE;
      det_vld_r <= 1'b0;
      lv_vld_r  <= '0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        mask_r <= cfg_chan.dedup_mask;
      end
      if (fire) begin
        args_r    <= args_nxt;
        kind_r    <= kind_nxt;
        high_r    <= high_nxt;
        lp_r      <= lp_nxt;
        det_vld_r <= det_vld_nxt;
        lv_vld_r  <= lv_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      det_r <= det_nxt;
      if (lv_we) begin
        lv_r[slot] <= lv_nxt;
      end
    end
  end

  a_args_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    args_r <= 3'd4)
    else $error("argument count out of range");
  a_held_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != KIND_NONE) |-> (lp_r == LEN_NONE && args_r != 3'd0))
    else $error("held command with pending length or no argument left");
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eos) |=> (kind_r == KIND_NONE && args_r == 3'd0 && lp_r == LEN_NONE
                       && !det_vld_r && lv_vld_r == '0))
    else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

### sv/rcf_queue.sv
// Group queue of the redundant command filter between parser and output
// serializer. Depends on rcf_pkg.
`default_nettype none

module rcf_queue
  import rcf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  rcf_push_t  push,
  input  wire logic  pop,
  output rcf_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  rcf_group_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign do_push = push.push;
  assign do_pop  = pop;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.head  = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push.grp;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> !qstat.full)
    else $error("group pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> !qstat.empty)
    else $error("group popped from empty queue");
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> push.grp.cnt != 2'd0)
    else $error("empty group pushed");

endmodule

`default_nettype wire

### sv/rcf_back.sv
// Output serializer of the redundant command filter: takes one group from
// the queue and sends its bytes one per transaction. Depends on rcf_pkg, rcf_if.
`default_nettype none

module rcf_back
  import rcf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  rcf_qstat_t qstat,
  output logic       pop,
  rcf_out_if.source  out_chan
);

  rcf_group_t grp_r;
  logic       vld_r;
  logic [1:0] pos_r;
  logic       take;
  logic       last;
  logic       done;

  assign last = (pos_r == grp_r.cnt - 2'd1);
  assign take = out_chan.valid && out_chan.ready;
  assign done = take && last;
  assign pop  = (!vld_r || done) && !qstat.empty;

  assign out_chan.valid    = vld_r;
  assign out_chan.out_byte = grp_r.bytes[pos_r];
  assign out_chan.run_last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= '0;
    end else if (pop) begin
      vld_r <= 1'b1;
      pos_r <= '0;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= qstat.head;
    end
  end

  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (grp_r.cnt != 2'd0 && pos_r < grp_r.cnt))
    else $error("serializer position outside its group");
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last) |=> (vld_r && pos_r == $past(pos_r) + 2'd1))
    else $error("serializer did not advance after a transaction");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(out_chan.out_byte)
                                             && $stable(out_chan.run_last)))
    else $error("output transaction changed while stalled");

endmodule

`default_nettype wire

### sv/redundant_command_filter.sv
// Redundant command filter. Accepts one stream byte per cycle while the
// group queue (QUEUE_DEPTH groups) has room. Each byte yields zero to three
// output bytes; the output side sends one byte per cycle while out_chan is
// ready, so sustained input rate equals one byte per cycle when each byte
// yields at most one result and out_chan is not stalled. The first output
// passes through the queue write and then the serializer load. dedup_mask
// is written over cfg_chan, which is always ready; the mask is sampled at
// each opcode byte. Depends on rcf_pkg, rcf_if and the rcf_ submodules.
`default_nettype none

module redundant_command_filter
  import rcf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rcf_in_if.sink    in_chan,
  rcf_out_if.source out_chan,
  rcf_cfg_if.sink   cfg_chan
);

  rcf_push_t  push;
  rcf_qstat_t qstat;
  logic       pop;

  rcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .qstat    (qstat),
    .push     (push)
  );

  rcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat)
  );

  rcf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
